// ----- rtl/fsfl_pkg.sv -----
// shared types and constants of the free-list slot allocator
`timescale 1ns / 1ps

package fsfl_pkg;

  localparam int DataW    = 32;
  localparam int ApbAddrW = 3;

  // register index, taken from paddr bit 2 (registers at byte addresses 4*i)
  localparam logic RegPoolBase = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_PTR   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_CALC = 3'b100
  } state_e;

endpackage

// ----- rtl/fixed_slot_free_list_allocator.sv -----
// top level of the fixed-slot pool allocator with a lifo free list
`timescale 1ns / 1ps

// Pool of NUM_SLOTS slots of SLOT_BYTES bytes each, slot i at byte address
// pool_base + i*SLOT_BYTES (wrapping at 2^32). Free slots form a lifo chain
// kept in a link memory plus a head register. An allocate transfer
// (tuser = 0) returns the head slot's address and pops it; when the chain
// is empty it returns status exhausted with a zero address. A free transfer
// (tuser = 1) pushes the slot holding tdata; an address outside the pool
// gives status bad pointer and changes nothing, an address inside a slot
// frees that slot, and freeing a slot twice is not caught. After reset
// the link memory is walked once to build the chain 0 -> 1 -> ... -> null,
// which is done with s_axis_tready low; register writes are
// taken during that time. Each item is then accepted in ST_IDLE, which reads
// the link at the head from the link memory; ST_CALC moves the head and,
// for a free, writes the freed slot's link. Items are handled one at a
// time; a result waits in the output register while the next item is
// accepted, and ST_CALC stalls only while that register is still full.
// pool_base may only be written while no item is in flight.
module fixed_slot_free_list_allocator #(
  parameter int NUM_SLOTS  = 64,
  parameter int SLOT_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [31:0] free_address
  input  logic [0:0]                    s_axis_tuser,   // [0] func
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] slot_address
  output logic [1:0]                    m_axis_tuser,   // [1:0] status
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsfl_pkg::ApbAddrW-1:0] paddr,
  input  logic [fsfl_pkg::DataW-1:0]    pwdata,
  output logic [fsfl_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int IdxW  = $clog2(NUM_SLOTS);
  localparam int LinkW = $clog2(NUM_SLOTS + 1);   // holds the null link too
  localparam int Span  = NUM_SLOTS * SLOT_BYTES;
  localparam int OffW  = $clog2(Span);
  localparam logic [LinkW-1:0] NullLink  = LinkW'(NUM_SLOTS);
  localparam logic [IdxW-1:0]  LastSlot  = IdxW'(NUM_SLOTS - 1);
  localparam logic [31:0]      SpanV     = 32'(Span);
  localparam logic [OffW-1:0]  SlotBytes = OffW'(SLOT_BYTES);

  fsfl_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]   init_q, init_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic              func_q;
  logic              in_range_q;
  logic [OffW-1:0]   off_q;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_addr_q, out_addr_d;
  fsfl_pkg::status_e out_status_q, out_status_d;

  logic [31:0]       pool_base;
  logic [31:0]       in_off;
  logic              in_xfer;
  logic              head_empty;
  logic              out_load;
  logic [IdxW-1:0]   free_idx;
  logic [OffW-1:0]   alloc_off;

  // link memory port
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [LinkW-1:0]  ram_wdata;
  logic              ram_re;
  logic [LinkW-1:0]  ram_rdata;

  fsfl_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pool_base_o (pool_base)
  );

  fsfl_ram #(
    .WIDTH (LinkW),
    .DEPTH (NUM_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  fsfl_slot_index #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_slot_index (
    .off_i (off_q),
    .idx_o (free_idx)
  );

  assign s_axis_tready = (state_q == fsfl_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign head_empty    = (head_q == NullLink);
  // offset into the pool, wraps like the address space
  assign in_off        = s_axis_tdata - pool_base;
  // result stage is free or drains this cycle
  assign out_load      = (state_q == fsfl_pkg::ST_CALC) && (!out_valid_q || m_axis_tready);
  // byte offset of the head slot, always below the pool span
  assign alloc_off     = OffW'(head_q[IdxW-1:0]) * SlotBytes;
  // fetch the head's link only when there is a head to pop
  assign ram_re        = in_xfer && !head_empty;

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = init_q;
    ram_wdata    = LinkW'(init_q) + LinkW'(1);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fsfl_pkg::ST_INIT: begin
        // build the initial chain, the last entry gets the null link
        ram_we = 1'b1;
        init_d = init_q + IdxW'(1);
        if (init_q == LastSlot) begin
          state_d = fsfl_pkg::ST_IDLE;
        end
      end
      fsfl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = fsfl_pkg::ST_CALC;
        end
      end
      fsfl_pkg::ST_CALC: begin
        if (out_load) begin
          state_d      = fsfl_pkg::ST_IDLE;
          out_valid_d  = 1'b1;
          out_addr_d   = '0;
          out_status_d = fsfl_pkg::STATUS_OK;
          if (!func_q) begin
            if (head_empty) begin
              out_status_d = fsfl_pkg::STATUS_EXHAUSTED;
            end else begin
              out_addr_d = pool_base + 32'(alloc_off);
              head_d     = ram_rdata;
            end
          end else if (!in_range_q) begin
            out_status_d = fsfl_pkg::STATUS_BAD_PTR;
          end else begin
            // push: freed slot links to the old head
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = head_q;
            head_d    = LinkW'(free_idx);
          end
        end
      end
      default: begin
        state_d = fsfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsfl_pkg::ST_INIT;
      init_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q     <= s_axis_tuser[0];
      in_range_q <= (in_off < SpanV);
      off_q      <= in_off[OffW-1:0];
    end
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- rtl/fsfl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module fsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fsfl_apb.sv -----
// apb register file holding the pool base address
`timescale 1ns / 1ps

module fsfl_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsfl_pkg::ApbAddrW-1:0] paddr,
  input  logic [fsfl_pkg::DataW-1:0]    pwdata,
  output logic [fsfl_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output logic [fsfl_pkg::DataW-1:0]    pool_base_o
);

  logic [fsfl_pkg::DataW-1:0] pool_base_q;
  logic                       hit_base;

  assign hit_base = (paddr[2] == fsfl_pkg::RegPoolBase);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (psel && penable && pwrite && pready && hit_base) begin
      pool_base_q <= pwdata;
    end
  end

  assign prdata      = hit_base ? pool_base_q : '0;
  assign pool_base_o = pool_base_q;

endmodule

// ----- rtl/fsfl_slot_index.sv -----
// pool offset to slot index, exact reciprocal multiply for a constant slot size
`timescale 1ns / 1ps

module fsfl_slot_index #(
  parameter int NUM_SLOTS  = 64,
  parameter int SLOT_BYTES = 8
) (
  input  logic [$clog2(NUM_SLOTS*SLOT_BYTES)-1:0] off_i,
  output logic [$clog2(NUM_SLOTS)-1:0]            idx_o
);

  localparam int OffW  = $clog2(NUM_SLOTS * SLOT_BYTES);
  localparam int IdxW  = $clog2(NUM_SLOTS);
  localparam int Shift = OffW + $clog2(SLOT_BYTES);
  localparam int RcpW  = OffW + 1;
  localparam int ProdW = OffW + RcpW;
  // ceil(2^Shift / SLOT_BYTES): exact quotient for every offset below 2^OffW
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES);
  localparam logic [RcpW-1:0] Recip = RecipFull[RcpW-1:0];

  logic [ProdW-1:0] prod;

  assign prod  = ProdW'(off_i) * ProdW'(Recip);
  assign idx_o = prod[Shift +: IdxW];

endmodule

// ----- rtl/fsfl_checker.sv -----
// port-level checks of the slot allocator, bound to the top level
`timescale 1ns / 1ps

module fsfl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == fsfl_pkg::STATUS_OK) ||
      (m_axis_tuser == fsfl_pkg::STATUS_EXHAUSTED) ||
      (m_axis_tuser == fsfl_pkg::STATUS_BAD_PTR))
    else $error("undefined status code");

  // every failure carries a zero address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fsfl_pkg::STATUS_OK) |-> m_axis_tdata == 32'd0)
    else $error("failed request returned an address");

  // one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

endmodule

bind fixed_slot_free_list_allocator fsfl_checker u_fsfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/tb.sv -----
// self-checking testbench of the fixed-slot pool allocator with a lifo free list
`timescale 1ns / 1ps

// The testbench drives allocate and free transfers into the input stream and
// keeps its own copy of the free chain (link per slot, head index, pool base).
// Every accepted transfer is run through that copy, and the result it gives
// is queued. The monitor compares each result transfer against the oldest
// queued result, field by field. The pool base is written over the register
// port only while nothing is in flight.
module tb;

  localparam int NumSlots       = 64;
  localparam int SlotBytes      = 8;
  localparam int PoolSpan       = NumSlots * SlotBytes;
  localparam int LinkW          = $clog2(NumSlots + 1);
  localparam int StallLimit     = 1000;
  localparam int SinkHoldCycles = 150;
  localparam logic [fsfl_pkg::ApbAddrW-1:0] PoolBaseAddr = {fsfl_pkg::RegPoolBase, 2'b00};

  typedef enum logic { OP_ALLOC = 1'b0, OP_FREE = 1'b1 } pool_op_e;

  typedef struct {
    pool_op_e    op;
    logic [31:0] addr;
  } pool_req_t;

  typedef struct {
    pool_op_e          op;
    logic [31:0]       slot_addr;
    fsfl_pkg::status_e status;
  } pool_resp_t;

  // block ports, all inputs known from time zero
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata  = '0;   // [31:0] free_address
  logic [0:0]                    s_axis_tuser  = '0;   // [0] func
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;         // [31:0] slot_address
  logic [1:0]                    m_axis_tuser;         // [1:0] status
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [fsfl_pkg::ApbAddrW-1:0] paddr         = '0;
  logic [fsfl_pkg::DataW-1:0]    pwdata        = '0;
  logic [fsfl_pkg::DataW-1:0]    prdata;
  logic                          pready;

  // shadow of the free chain
  logic [LinkW-1:0] link_model [NumSlots];
  logic [LinkW-1:0] head_model;
  logic [31:0]      base_model;

  pool_req_t   pending_ops_q[$];   // transfers waiting for the driver
  pool_resp_t  slot_results_q[$];  // results still owed by the block
  logic [31:0] base_writes_q[$];   // pool base values waiting for the register port
  int          held_slots_q[$];    // slot indices handed out and not yet freed

  int  src_gap       = 0;
  int  sink_gap      = 0;
  int  sink_hold     = 0;
  bit  sink_hold_req = 1'b0;
  bit  idle_on       = 1'b1;
  int  stall_cnt     = 0;
  int  mismatch_cnt  = 0;
  int  n_alloc_ok    = 0;
  int  n_exhausted   = 0;
  int  n_free_ok     = 0;
  int  n_bad_ptr     = 0;
  int  n_base_writes = 0;

  fixed_slot_free_list_allocator #(
    .NUM_SLOTS (NumSlots),
    .SLOT_BYTES(SlotBytes)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 30) $display("[%0t] error: %s", $time, what);
  endtask

  // chain after reset: 0 -> 1 -> ... -> last -> null
  task automatic reset_pool_model();
    for (int i = 0; i < NumSlots; i++) link_model[i] = LinkW'(i + 1);
    head_model = '0;
    base_model = '0;
  endtask

  // one accepted transfer: update the shadow chain and queue the result
  task automatic pool_model_step(input pool_op_e op, input logic [31:0] addr);
    pool_resp_t       r;
    logic [31:0]      offset;
    logic [LinkW-1:0] idx;
    r.op        = op;
    r.slot_addr = '0;
    r.status    = fsfl_pkg::STATUS_OK;
    if (op == OP_ALLOC) begin
      if (head_model >= NumSlots) begin
        // null head: nothing to hand out
        r.status = fsfl_pkg::STATUS_EXHAUSTED;
        n_exhausted++;
      end else begin
        r.slot_addr = base_model + 32'(head_model) * SlotBytes;
        head_model  = link_model[head_model];
        n_alloc_ok++;
      end
    end else begin
      // range check on the wrapped offset, so a pool across 2^32 still works
      offset = addr - base_model;
      if (offset >= PoolSpan) begin
        r.status = fsfl_pkg::STATUS_BAD_PTR;
        n_bad_ptr++;
      end else begin
        // any byte of a slot frees that slot, double frees go through
        idx             = LinkW'(offset / SlotBytes);
        link_model[idx] = head_model;
        head_model      = idx;
        n_free_ok++;
      end
    end
    slot_results_q.push_back(r);
  endtask

  // driver: offers queued transfers, with random gaps between them
  always @(posedge clk_i) begin : src_drv
    pool_req_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_model_step(pool_op_e'(s_axis_tuser[0]), s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops_q.size() != 0) begin
          nxt = pending_ops_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.addr;
          s_axis_tuser  <= nxt.op;
          if (idle_on && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and throttles tready
  always @(posedge clk_i) begin : sink_mon
    pool_resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_results_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: addr %h status %0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = slot_results_q.pop_front();
          if (m_axis_tdata !== want.slot_addr)
            report_mismatch($sformatf("slot_address %h, expected %h",
                                      m_axis_tdata, want.slot_addr));
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                      m_axis_tuser, want.status, want.status.name()));
          // remember handed-out slots so later frees can return them
          if (want.op == OP_ALLOC && want.status == fsfl_pkg::STATUS_OK)
            held_slots_q.push_back(int'((want.slot_addr - base_model) / SlotBytes));
        end
      end
      // long hold-off: the block fills up and must stall its input
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_hold     = SinkHoldCycles;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  // register port: setup cycle, then access cycle
  always @(posedge clk_i) begin : apb_drv
    if (rst_ni) begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          base_model = pwdata;
          n_base_writes++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
      end else if (psel && !penable) begin
        penable <= 1'b1;
      end else if (!psel && base_writes_q.size() != 0) begin
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= PoolBaseAddr;
        pwdata <= base_writes_q.pop_front();
      end
    end
  end

  // watchdog: cycles with no transfer anywhere
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_op(input pool_op_e op, input logic [31:0] addr);
    pool_req_t r;
    r.op   = op;
    r.addr = addr;
    pending_ops_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_ops_q.size() != 0 || s_axis_tvalid || slot_results_q.size() != 0)
      @(negedge clk_i);
  endtask

  // pool base changes only with nothing in flight
  task automatic write_pool_base(input logic [31:0] value);
    wait_drained();
    base_writes_q.push_back(value);
    do @(negedge clk_i); while (base_writes_q.size() != 0 || psel);
  endtask

  // free address that misses the pool, or with in_pool set, often any pool byte
  function automatic logic [31:0] wild_address(input bit in_pool);
    logic [31:0] off;
    case ($urandom_range(0, 3))
      0: off = PoolSpan + $urandom_range(0, 15);
      1: off = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: begin
        off = $urandom;
        if (off < PoolSpan) off = off + PoolSpan;
      end
    endcase
    if (in_pool && $urandom_range(0, 1) == 1) off = $urandom_range(0, PoolSpan - 1);
    return base_model + off;
  endfunction

  // mostly allocates and frees of held slots, the rest wild frees
  task automatic gen_phase(input int n, input int alloc_pct, input int wild_pct,
                           input bit wild_in_pool);
    int pick;
    int k;
    repeat (n) begin
      while (pending_ops_q.size() >= 4) @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct ||
          (pick >= alloc_pct + wild_pct && held_slots_q.size() == 0)) begin
        push_op(OP_ALLOC, $urandom);
      end else if (pick < alloc_pct + wild_pct) begin
        push_op(OP_FREE, wild_address(wild_in_pool));
      end else begin
        // return a held slot, through any of its bytes
        k = $urandom_range(0, held_slots_q.size() - 1);
        push_op(OP_FREE, base_model + held_slots_q[k] * SlotBytes +
                         $urandom_range(0, SlotBytes - 1));
        held_slots_q.delete(k);
      end
    end
  endtask

  initial begin : stimulus
    int dup_slot;
    reset_pool_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // written while the chain is still being built; slot 2 onward wraps to 0
    write_pool_base(32'hFFFF_FFF0);

    // directed: allocates, wrap, misaligned and edge frees, out-of-range frees
    repeat (4) push_op(OP_ALLOC, $urandom);   // slots 0..3, slot 2 at address 0
    push_op(OP_FREE, 32'h0000_0007);          // last byte of slot 2
    push_op(OP_FREE, 32'hFFFF_FFFF);          // all-ones address, last byte of slot 1
    push_op(OP_FREE, 32'h0000_01F0);          // one past the pool end
    push_op(OP_FREE, 32'hFFFF_FFEF);          // one below the base
    push_op(OP_FREE, 32'h7FFF_FFFF);
    push_op(OP_FREE, 32'h8000_0000);
    push_op(OP_ALLOC, 32'h0000_0000);         // slot 1 again
    push_op(OP_ALLOC, 32'hFFFF_FFFF);         // slot 2 again
    push_op(OP_ALLOC, $urandom);              // slot 4
    push_op(OP_FREE, 32'hFFFF_FFF0);          // exact start of slot 0
    push_op(OP_FREE, 32'h0000_0013);          // inside slot 4
    push_op(OP_FREE, 32'h0000_0008);          // exact start of slot 3
    repeat (4) push_op(OP_ALLOC, $urandom);   // slots 3, 4, 0, 5
    wait_drained();
    // after the directed part slots 0..5 are out
    held_slots_q = '{0, 1, 2, 3, 4, 5};

    // run the pool dry while the receiver holds off for a long stretch
    sink_hold_req = 1'b1;
    gen_phase(70, 100, 0, 1'b0);
    gen_phase(120, 25, 10, 1'b0);

    write_pool_base(32'h0000_0000);
    gen_phase(200, 50, 10, 1'b0);

    write_pool_base($urandom);
    gen_phase(150, 75, 5, 1'b0);
    // sender pauses until every result is back
    wait_drained();
    gen_phase(100, 20, 10, 1'b0);

    // double free: the slot links to itself and comes out on every allocate that finds it at the head;
    // from here on the chain loops and can no longer run dry
    push_op(OP_ALLOC, $urandom);
    wait_drained();
    if (held_slots_q.size() != 0) begin
      dup_slot = held_slots_q.pop_back();
      push_op(OP_FREE, base_model + dup_slot * SlotBytes);
      push_op(OP_FREE, base_model + dup_slot * SlotBytes + SlotBytes - 1);
    end
    repeat (3) push_op(OP_ALLOC, $urandom);

    write_pool_base(32'hFFFF_FFFF);
    gen_phase(250, 50, 20, 1'b1);

    // last stretch with no idling on either side
    write_pool_base(32'h7FFF_FFF8);
    idle_on = 1'b0;
    gen_phase(420, 50, 20, 1'b1);

    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("covered %0d allocates (%0d empty pool), %0d frees (%0d bad pointer)",
             n_alloc_ok + n_exhausted, n_exhausted, n_free_ok + n_bad_ptr, n_bad_ptr);
    $display("over %0d pool base settings incl. wrap at the top of the address space",
             n_base_writes);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fsfl_pkg.sv
rtl/fsfl_ram.sv
rtl/fsfl_apb.sv
rtl/fsfl_slot_index.sv
rtl/fixed_slot_free_list_allocator.sv
rtl/fsfl_checker.sv
verif/tb.sv
